// ===== rtl/kalman_cv_tracker_1d_assert.svh =====
// assertion macros for the tracker, expanded only in simulation
`ifndef KALMAN_CV_TRACKER_1D_ASSERT_SVH
`define KALMAN_CV_TRACKER_1D_ASSERT_SVH
`ifndef SYNTHESIS
`define KCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define KCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KCT_ASSERT_NOW(label, ante, cons, msg)
`define KCT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/kct_pkg.sv =====
package kct_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int SIG_BITS   = 32;
   localparam int COV_BITS   = 48;
   localparam int WIDE_BITS  = 60;
   localparam int GAIN_FRAC  = 32;
   localparam int DT_BITS    = 21;
   localparam int Y_BITS     = SIG_BITS + 1;
   localparam int MAG_BITS   = 64;
   localparam int PROD_BITS  = 2 * MAG_BITS;
   localparam int DIGIT_BITS = 16;
   localparam int DIGITS     = MAG_BITS / DIGIT_BITS;
   localparam int DIV_STEPS  = COV_BITS + GAIN_FRAC + 1;
   localparam int PC_BITS    = 6;

   localparam logic CSR_PROCESS_VAR = 1'b0;
   localparam logic CSR_MEAS_VAR    = 1'b1;

   localparam logic [6:0] SH_0  = 7'd0;
   localparam logic [6:0] SH_F  = 7'(FRAC_BITS);
   localparam logic [6:0] SH_F1 = 7'(FRAC_BITS + 1);
   localparam logic [6:0] SH_G  = 7'(GAIN_FRAC);

   localparam logic signed [63:0] TOP_SIG  = (64'sd1 <<< (SIG_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] TOP_COV  = (64'sd1 <<< (COV_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] TOP_WIDE = (64'sd1 <<< (WIDE_BITS - 1)) - 64'sd1;

   typedef enum logic [2:0] {
      OP_MUL, OP_DIV, OP_SET, OP_ADD, OP_SUB, OP_STORE, OP_END
   } op_type;

   typedef enum logic [4:0] {
      R_DT, R_MEAS, R_PV, R_MVS, R_POS, R_RATE, R_C00, R_C01, R_C10, R_C11,
      R_DT2, R_Q11, R_Q01, R_Q00, R_P00, R_P01, R_P10, R_P11, R_K0, R_K1,
      R_Y, R_T, R_S
   } reg_id_type;

   typedef enum logic [1:0] { W32, W48, W60 } wsel_type;

   typedef enum logic [2:0] { ST_IDLE, ST_INIT, ST_EXEC, ST_WAIT, ST_DONE } state_type;

   typedef struct packed {
      op_type     op;
      reg_id_type a;
      reg_id_type b;
      logic [6:0] sh;
      wsel_type   w;
      reg_id_type dst;
   } uop_type;

   typedef struct packed {
      logic    accept;
      logic    init;
      logic    start;
      logic    step;
      logic    out_load;
      uop_type uop;
   } cmd_type;

   typedef struct packed {
      logic unit_done;
   } status_type;

   function automatic logic signed [63:0] top_of(input wsel_type w);
      case (w)
         W32:     return TOP_SIG;
         W48:     return TOP_COV;
         default: return TOP_WIDE;
      endcase
   endfunction

   function automatic logic signed [63:0] sat_sig(input logic signed [63:0] v,
                                                   input wsel_type w);
      logic signed [63:0] top;
      top = top_of(w);
      if (v > top) return top;
      if (v < -top - 64'sd1) return -top - 64'sd1;
      return v;
   endfunction

   function automatic logic signed [63:0] sat_mag(input logic neg,
                                                   input logic [PROD_BITS-1:0] m,
                                                   input wsel_type w);
      logic [PROD_BITS-1:0] lim;
      logic [PROD_BITS-1:0] v;
      lim = {64'd0, top_of(w)} + {127'd0, neg};
      v = (m > lim) ? lim : m;
      return neg ? -$signed(v[63:0]) : $signed(v[63:0]);
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic uop_type u_mul(input reg_id_type a, input reg_id_type b,
                                     input logic [6:0] sh, input wsel_type w,
                                     input reg_id_type d);
      return '{OP_MUL, a, b, sh, w, d};
   endfunction

   function automatic uop_type u_acc(input op_type op, input reg_id_type a);
      return '{op, a, R_DT, SH_0, W60, R_DT};
   endfunction

   function automatic uop_type u_st(input reg_id_type d, input wsel_type w);
      return '{OP_STORE, R_DT, R_DT, SH_0, w, d};
   endfunction

   function automatic uop_type u_div(input reg_id_type a, input reg_id_type d);
      return '{OP_DIV, a, R_S, SH_0, W48, d};
   endfunction

   // predict and update sequence for one measurement
   function automatic uop_type prog(input logic [PC_BITS-1:0] pc);
      case (pc)
         6'd0:  return u_mul(R_DT, R_DT, SH_F, W60, R_DT2);
         6'd1:  return u_mul(R_DT2, R_PV, SH_0, W48, R_Q11);
         6'd2:  return u_mul(R_Q11, R_DT, SH_F1, W48, R_Q01);
         6'd3:  return u_mul(R_Q01, R_DT, SH_F1, W48, R_Q00);
         6'd4:  return u_mul(R_RATE, R_DT, SH_F, W60, R_T);
         6'd5:  return u_acc(OP_SET, R_POS);
         6'd6:  return u_acc(OP_ADD, R_T);
         6'd7:  return u_st(R_POS, W32);
         6'd8:  return u_mul(R_C01, R_DT, SH_F, W60, R_T);
         6'd9:  return u_acc(OP_SET, R_C00);
         6'd10: return u_acc(OP_ADD, R_T);
         6'd11: return u_mul(R_C10, R_DT, SH_F, W60, R_T);
         6'd12: return u_acc(OP_ADD, R_T);
         6'd13: return u_mul(R_C11, R_DT2, SH_F, W60, R_T);
         6'd14: return u_acc(OP_ADD, R_T);
         6'd15: return u_acc(OP_ADD, R_Q00);
         6'd16: return u_st(R_P00, W48);
         6'd17: return u_mul(R_C11, R_DT, SH_F, W60, R_T);
         6'd18: return u_acc(OP_SET, R_C01);
         6'd19: return u_acc(OP_ADD, R_T);
         6'd20: return u_acc(OP_ADD, R_Q01);
         6'd21: return u_st(R_P01, W48);
         6'd22: return u_acc(OP_SET, R_C10);
         6'd23: return u_acc(OP_ADD, R_T);
         6'd24: return u_acc(OP_ADD, R_Q01);
         6'd25: return u_st(R_P10, W48);
         6'd26: return u_acc(OP_SET, R_C11);
         6'd27: return u_acc(OP_ADD, R_Q11);
         6'd28: return u_st(R_P11, W48);
         6'd29: return u_acc(OP_SET, R_P00);
         6'd30: return u_acc(OP_ADD, R_MVS);
         6'd31: return u_st(R_S, W60);
         6'd32: return u_div(R_P00, R_K0);
         6'd33: return u_div(R_P10, R_K1);
         6'd34: return u_acc(OP_SET, R_MEAS);
         6'd35: return u_acc(OP_SUB, R_POS);
         6'd36: return u_st(R_Y, W60);
         6'd37: return u_mul(R_Y, R_K0, SH_G, W60, R_T);
         6'd38: return u_acc(OP_SET, R_POS);
         6'd39: return u_acc(OP_ADD, R_T);
         6'd40: return u_st(R_POS, W32);
         6'd41: return u_mul(R_Y, R_K1, SH_G, W60, R_T);
         6'd42: return u_acc(OP_SET, R_RATE);
         6'd43: return u_acc(OP_ADD, R_T);
         6'd44: return u_st(R_RATE, W32);
         6'd45: return u_mul(R_K0, R_P00, SH_G, W60, R_T);
         6'd46: return u_acc(OP_SET, R_P00);
         6'd47: return u_acc(OP_SUB, R_T);
         6'd48: return u_st(R_C00, W48);
         6'd49: return u_mul(R_K0, R_P01, SH_G, W60, R_T);
         6'd50: return u_acc(OP_SET, R_P01);
         6'd51: return u_acc(OP_SUB, R_T);
         6'd52: return u_st(R_C01, W48);
         6'd53: return u_mul(R_K1, R_P00, SH_G, W60, R_T);
         6'd54: return u_acc(OP_SET, R_P10);
         6'd55: return u_acc(OP_SUB, R_T);
         6'd56: return u_st(R_C10, W48);
         6'd57: return u_mul(R_K1, R_P01, SH_G, W60, R_T);
         6'd58: return u_acc(OP_SET, R_P11);
         6'd59: return u_acc(OP_SUB, R_T);
         6'd60: return u_st(R_C11, W48);
         default: return '{OP_END, R_DT, R_DT, SH_0, W60, R_DT};
      endcase
   endfunction

endpackage

// ===== rtl/kalman_cv_tracker_1d.sv =====
// one-dimensional constant-velocity tracker
// request channel: req_valid/req_ready carrying reset_filter, time_step (Q5.16)
// and measurement (Q16.16). response channel: rsp_valid/rsp_ready carrying the
// position and rate estimates (Q16.16, saturating). csr_wr_en with csr_index
// and csr_wdata writes process variance (index 0) or measurement variance
// (index 1); write only while no request is in flight.
// a reset_filter request passes from acceptance through the init and done
// states to the response register. a tracking request is run by a microcoded
// sequencer that drives 15 products through a 64x16 multiplier and two gain
// divisions through a restoring divider at one quotient bit per cycle,
// with an accumulate or store step for each other micro-op.
// one request is worked on at a time; a new request is accepted as soon as the
// previous result sits in the response register, even if it is not yet taken.
// if the receiver stalls, a finished result waits in the sequencer until the
// response register frees up.
// reset clears position, rate and covariance, sets both variances to 1.0 and
// leaves both channels empty.
`include "kalman_cv_tracker_1d_assert.svh"
module kalman_cv_tracker_1d (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_reset_filter,
   input  logic [kct_pkg::DT_BITS-1:0]         req_time_step,
   input  logic signed [kct_pkg::SIG_BITS-1:0] req_measurement,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [kct_pkg::SIG_BITS-1:0] rsp_position_estimate,
   output logic signed [kct_pkg::SIG_BITS-1:0] rsp_rate_estimate,
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [31:0]                         csr_wdata
);
   import kct_pkg::*;

   cmd_type    cmd;
   status_type status;

   kct_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_reset_filter (req_reset_filter),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .status           (status),
      .cmd              (cmd)
   );

   kct_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_time_step         (req_time_step),
      .req_measurement       (req_measurement),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_position_estimate (rsp_position_estimate),
      .rsp_rate_estimate     (rsp_rate_estimate)
   );

   `KCT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   `KCT_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid || rsp_ready, "response overwritten")
   `KCT_ASSERT_NEXT(a_load_shows, cmd.out_load, rsp_valid, "loaded response not valid")
   `KCT_ASSERT_NOW(a_done_only_waiting, status.unit_done, !req_ready, "unit done while idle")

endmodule

// ===== rtl/kct_mul.sv =====
module kct_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  op_a,
   input  logic signed [63:0]  op_b,
   input  logic [6:0]          shift,
   input  kct_pkg::wsel_type   wsel,
   output logic                done,
   output logic signed [63:0]  result
);
   import kct_pkg::*;

   logic [MAG_BITS-1:0]  ma_ff, mb_ff;
   logic [PROD_BITS-1:0] prod_ff;
   logic                 neg_ff;
   logic [6:0]           sh_ff;
   wsel_type             w_ff;
   logic [1:0]           cnt_ff;
   logic                 busy_ff, fin_ff;

   logic [MAG_BITS+DIGIT_BITS-1:0] partial;
   logic [PROD_BITS-1:0]           half, rounded;

   // one 16-bit digit of the multiplier per cycle
   assign partial = ma_ff * mb_ff[DIGIT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'(DIGITS - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff   <= mag64(op_a);
         mb_ff   <= mag64(op_b);
         prod_ff <= '0;
         neg_ff  <= op_a[63] ^ op_b[63];
         sh_ff   <= shift;
         w_ff    <= wsel;
      end else if (busy_ff) begin
         prod_ff <= prod_ff + (PROD_BITS'(partial) << (cnt_ff * DIGIT_BITS));
         mb_ff   <= mb_ff >> DIGIT_BITS;
      end
   end

   // round half away from zero on the magnitude
   assign half    = (sh_ff == SH_0) ? '0 : (PROD_BITS'(1) << (sh_ff - 7'd1));
   assign rounded = (prod_ff + half) >> sh_ff;
   assign result  = sat_mag(neg_ff, rounded, w_ff);
   assign done    = fin_ff;

endmodule

// ===== rtl/kct_div.sv =====
module kct_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  numer,
   input  logic signed [63:0]  denom,
   output logic                done,
   output logic signed [63:0]  result
);
   import kct_pkg::*;

   logic [DIV_STEPS-1:0]  n_ff, q_ff;
   logic [WIDE_BITS-1:0]  d_ff;
   logic [WIDE_BITS:0]    rem_ff;
   logic                  neg_ff, zero_ff;
   logic [6:0]            cnt_ff;
   logic                  busy_ff, fin_ff;

   logic [63:0]           pm;
   logic [WIDE_BITS:0]    trial;
   logic                  fits;

   assign pm    = mag64(numer);
   assign trial = {rem_ff[WIDE_BITS-1:0], n_ff[DIV_STEPS-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   // restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         n_ff    <= DIV_STEPS'({pm[COV_BITS-1:0], GAIN_FRAC'(0)})
                    + DIV_STEPS'(denom[WIDE_BITS-1:1]);
         d_ff    <= denom[WIDE_BITS-1:0];
         rem_ff  <= '0;
         q_ff    <= '0;
         neg_ff  <= numer[63];
         zero_ff <= (denom <= 64'sd0);
      end else if (busy_ff) begin
         n_ff   <= n_ff << 1;
         rem_ff <= fits ? trial - {1'b0, d_ff} : trial;
         q_ff   <= {q_ff[DIV_STEPS-2:0], fits};
      end
   end

   // gains are zero when the innovation variance is not positive
   assign result = zero_ff ? 64'sd0 : sat_mag(neg_ff, PROD_BITS'(q_ff), W48);
   assign done   = fin_ff;

endmodule

// ===== rtl/kct_ctrl.sv =====
module kct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_reset_filter,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kct_pkg::status_type status,
   output kct_pkg::cmd_type    cmd
);
   import kct_pkg::*;

   state_type           state_ff, state_in;
   logic [PC_BITS-1:0]  pc_ff, pc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   uop_type             uop;

   assign uop = prog(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.uop   = uop;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               pc_in      = '0;
               state_in   = req_reset_filter ? ST_INIT : ST_EXEC;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_DONE;
         end
         ST_EXEC: begin
            case (uop.op) inside
               OP_MUL, OP_DIV: begin
                  cmd.start = 1'b1;
                  state_in  = ST_WAIT;
               end
               OP_END: state_in = ST_DONE;
               default: begin
                  cmd.step = 1'b1;
                  pc_in    = pc_ff + 6'd1;
               end
            endcase
         end
         ST_WAIT: begin
            if (status.unit_done) begin
               pc_in    = pc_ff + 6'd1;
               state_in = ST_EXEC;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== rtl/kct_dp.sv =====
module kct_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  kct_pkg::cmd_type                  cmd,
   output kct_pkg::status_type               status,
   input  logic [kct_pkg::DT_BITS-1:0]       req_time_step,
   input  logic signed [kct_pkg::SIG_BITS-1:0] req_measurement,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [31:0]                       csr_wdata,
   output logic signed [kct_pkg::SIG_BITS-1:0] rsp_position_estimate,
   output logic signed [kct_pkg::SIG_BITS-1:0] rsp_rate_estimate
);
   import kct_pkg::*;

   logic [31:0]                 pv_ff, mv_ff;
   logic signed [SIG_BITS-1:0]  pos_ff, rate_ff, meas_ff;
   logic signed [COV_BITS-1:0]  c00_ff, c01_ff, c10_ff, c11_ff;
   logic [DT_BITS-1:0]          dt_ff;
   logic signed [WIDE_BITS-1:0] dt2_ff, t_ff, s_ff;
   logic signed [COV_BITS-1:0]  q11_ff, q01_ff, q00_ff;
   logic signed [COV_BITS-1:0]  p00_ff, p01_ff, p10_ff, p11_ff, k0_ff, k1_ff;
   logic signed [Y_BITS-1:0]    y_ff;
   logic signed [63:0]          acc_ff;
   logic signed [SIG_BITS-1:0]  out_pos_ff, out_rate_ff;

   logic signed [63:0] rd_a, rd_b, mul_res, div_res, wr_val;
   logic               mul_done, div_done, wr_en;
   reg_id_type         wr_id;
   uop_type            uop;

   assign uop = cmd.uop;

   function automatic logic signed [63:0] rd(input reg_id_type id);
      case (id)
         R_DT:    return $signed(64'(dt_ff));
         R_MEAS:  return 64'(meas_ff);
         R_PV:    return $signed(64'(pv_ff));
         R_MVS:   return $signed(64'({mv_ff, FRAC_BITS'(0)}));
         R_POS:   return 64'(pos_ff);
         R_RATE:  return 64'(rate_ff);
         R_C00:   return 64'(c00_ff);
         R_C01:   return 64'(c01_ff);
         R_C10:   return 64'(c10_ff);
         R_C11:   return 64'(c11_ff);
         R_DT2:   return 64'(dt2_ff);
         R_Q11:   return 64'(q11_ff);
         R_Q01:   return 64'(q01_ff);
         R_Q00:   return 64'(q00_ff);
         R_P00:   return 64'(p00_ff);
         R_P01:   return 64'(p01_ff);
         R_P10:   return 64'(p10_ff);
         R_P11:   return 64'(p11_ff);
         R_K0:    return 64'(k0_ff);
         R_K1:    return 64'(k1_ff);
         R_Y:     return 64'(y_ff);
         R_T:     return 64'(t_ff);
         R_S:     return 64'(s_ff);
         default: return 64'sd0;
      endcase
   endfunction

   assign rd_a = rd(uop.a);
   assign rd_b = rd(uop.b);

   kct_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start && uop.op == OP_MUL),
      .op_a   (rd_a),
      .op_b   (rd_b),
      .shift  (uop.sh),
      .wsel   (uop.w),
      .done   (mul_done),
      .result (mul_res)
   );

   kct_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start && uop.op == OP_DIV),
      .numer  (rd_a),
      .denom  (rd_b),
      .done   (div_done),
      .result (div_res)
   );

   assign status.unit_done = mul_done | div_done;

   assign wr_en  = mul_done | div_done | (cmd.step && uop.op == OP_STORE);
   assign wr_id  = uop.dst;
   assign wr_val = mul_done ? mul_res : (div_done ? div_res : sat_sig(acc_ff, uop.w));

   // filter state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff   <= 32'd65536;
         mv_ff   <= 32'd65536;
         pos_ff  <= '0;
         rate_ff <= '0;
         c00_ff  <= '0;
         c01_ff  <= '0;
         c10_ff  <= '0;
         c11_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PROCESS_VAR: pv_ff <= csr_wdata;
               CSR_MEAS_VAR:    mv_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.init) begin
            pos_ff  <= meas_ff;
            rate_ff <= '0;
            c00_ff  <= '0;
            c01_ff  <= '0;
            c10_ff  <= '0;
            c11_ff  <= '0;
         end else if (wr_en) begin
            case (wr_id)
               R_POS:   pos_ff  <= wr_val[SIG_BITS-1:0];
               R_RATE:  rate_ff <= wr_val[SIG_BITS-1:0];
               R_C00:   c00_ff  <= wr_val[COV_BITS-1:0];
               R_C01:   c01_ff  <= wr_val[COV_BITS-1:0];
               R_C10:   c10_ff  <= wr_val[COV_BITS-1:0];
               R_C11:   c11_ff  <= wr_val[COV_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // per-request working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dt_ff   <= req_time_step;
         meas_ff <= req_measurement;
      end
      if (cmd.step) begin
         case (uop.op)
            OP_SET:  acc_ff <= rd_a;
            OP_ADD:  acc_ff <= acc_ff + rd_a;
            OP_SUB:  acc_ff <= acc_ff - rd_a;
            default: ;
         endcase
      end
      if (wr_en) begin
         case (wr_id)
            R_DT2:   dt2_ff <= wr_val[WIDE_BITS-1:0];
            R_T:     t_ff   <= wr_val[WIDE_BITS-1:0];
            R_S:     s_ff   <= wr_val[WIDE_BITS-1:0];
            R_Q11:   q11_ff <= wr_val[COV_BITS-1:0];
            R_Q01:   q01_ff <= wr_val[COV_BITS-1:0];
            R_Q00:   q00_ff <= wr_val[COV_BITS-1:0];
            R_P00:   p00_ff <= wr_val[COV_BITS-1:0];
            R_P01:   p01_ff <= wr_val[COV_BITS-1:0];
            R_P10:   p10_ff <= wr_val[COV_BITS-1:0];
            R_P11:   p11_ff <= wr_val[COV_BITS-1:0];
            R_K0:    k0_ff  <= wr_val[COV_BITS-1:0];
            R_K1:    k1_ff  <= wr_val[COV_BITS-1:0];
            R_Y:     y_ff   <= wr_val[Y_BITS-1:0];
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         out_pos_ff  <= cmd.init ? meas_ff : pos_ff;
         out_rate_ff <= rate_ff;
      end
   end

   assign rsp_position_estimate = out_pos_ff;
   assign rsp_rate_estimate     = out_rate_ff;

endmodule
